// ===== hw/rtl/pbrd_pkg.sv =====
// shared types and constants of the pulse beat rate detector
package pbrd_pkg;

  localparam int unsigned SampleW   = 12;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned RateW     = 16;
  localparam int unsigned RefrW     = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned DivCntW   = 4;
  localparam int unsigned RemW      = RateW + 1;
  localparam int unsigned InDataW   = 48;

  localparam logic [SampleW-1:0] ThresholdReset  = 12'd2800;
  localparam logic [SampleW-1:0] HysteresisReset = 12'd300;
  localparam logic [RefrW-1:0]   RefractoryReset = 16'd400;
  localparam logic [RateW-1:0]   RateNumerator   = 16'd60000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_HYSTERESIS = 2'd1,
    CFG_REFRACTORY = 2'd2
  } cfg_reg_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic eval;
    logic div_step;
    logic load_out;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic fire;
    logic div_last;
  } sts_t;

endpackage

// ===== hw/rtl/pbrd_ctrl.sv =====
// controller state machine: sequences capture, evaluation, division and output
module pbrd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  input  pbrd_pkg::sts_t  sts_i,
  output pbrd_pkg::cmd_t  cmd_o
);
  import pbrd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.fire ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/pbrd_dp.sv =====
// datapath: registers, beat decision and restoring rate divider
module pbrd_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pbrd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [pbrd_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic [pbrd_pkg::SampleW-1:0]      sample_i,
  input  logic [pbrd_pkg::TimeW-1:0]        time_ms_i,
  input  pbrd_pkg::cmd_t                    cmd_i,
  output pbrd_pkg::sts_t                    sts_o,
  output logic [pbrd_pkg::RateW-1:0]        beats_per_minute_o,
  output logic                              new_beat_o
);
  import pbrd_pkg::*;

  logic [SampleW-1:0] thr_q, hyst_q;
  logic [RefrW-1:0]   refr_q;
  logic [TimeW-1:0]   last_time_q;
  logic               latched_q;
  logic [RateW-1:0]   held_rate_q;
  logic               fired_q;
  logic [DivCntW-1:0] cnt_q;

  logic [SampleW-1:0] smp_q;
  logic [TimeW-1:0]   time_q;
  logic [TimeW-1:0]   divisor_q;
  logic [RemW-1:0]    rem_q;
  logic [RateW-1:0]   quo_q;
  logic [RateW-1:0]   bpm_q;
  logic               nb_q;

  logic [SampleW-1:0] rearm_level;
  logic [TimeW-1:0]   interval;
  logic               above, below, fire;
  logic [RemW-1:0]    rem_shift, rem_d;
  logic [RateW-1:0]   quo_d;
  logic               fits;

  assign rearm_level = (thr_q > hyst_q) ? (thr_q - hyst_q) : '0;
  assign interval    = time_q - last_time_q;
  assign above       = (smp_q > thr_q);
  assign below       = (smp_q < rearm_level);
  assign fire        = above && !latched_q && (interval > {{(TimeW-RefrW){1'b0}}, refr_q});

  assign sts_o.fire     = fire;
  assign sts_o.div_last = &cnt_q;

  // one quotient bit per step, numerator bits shifted out of the quotient register
  always_comb begin
    rem_shift = {rem_q[RemW-2:0], quo_q[RateW-1]};
    fits      = ({{(TimeW-RemW){1'b0}}, rem_shift} >= divisor_q);
    if (fits) begin
      rem_d = rem_shift - divisor_q[RemW-1:0];
      quo_d = {quo_q[RateW-2:0], 1'b1};
    end else begin
      rem_d = rem_shift;
      quo_d = {quo_q[RateW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= ThresholdReset;
      hyst_q      <= HysteresisReset;
      refr_q      <= RefractoryReset;
      last_time_q <= '0;
      latched_q   <= 1'b0;
      held_rate_q <= '0;
      fired_q     <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_THRESHOLD:  thr_q  <= cfg_data_i[SampleW-1:0];
          CFG_HYSTERESIS: hyst_q <= cfg_data_i[SampleW-1:0];
          CFG_REFRACTORY: refr_q <= cfg_data_i[RefrW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.eval) begin
        fired_q <= fire;
        cnt_q   <= '0;
        if (fire) begin
          last_time_q <= time_q;
          latched_q   <= 1'b1;
        end else if (!above && below) begin
          latched_q <= 1'b0;
        end
      end
      if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
        if (&cnt_q) begin
          held_rate_q <= quo_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      smp_q  <= sample_i;
      time_q <= time_ms_i;
    end
    if (cmd_i.eval) begin
      divisor_q <= interval;
      rem_q     <= '0;
      quo_q     <= RateNumerator;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.load_out) begin
      bpm_q <= held_rate_q;
      nb_q  <= fired_q;
    end
  end

  assign beats_per_minute_o = bpm_q;
  assign new_beat_o         = nb_q;

endmodule

// ===== hw/rtl/pulse_beat_rate_detector_top.sv =====
// Pulse beat rate detector, top level.
//
// Input stream: one transfer per sensor sample, carrying the 12-bit reading
// and its millisecond timestamp. Output stream: one transfer per input
// transfer, carrying the held rate in beats per minute and a new-beat flag.
// The user must write registers (threshold, re-arm hysteresis, refractory
// time) through the cfg port while no sample is in flight; not enforced.
//
// Sequencing: a sample that is not taken as a beat is captured, evaluated and
// then loaded into the output register once that is free. A sample taken as a
// beat runs the 16-step restoring divider (60000 / interval, one quotient bit
// per cycle) between evaluation and load. The input is taken again in the
// cycle after the result is loaded into the output register, so the block
// takes no new sample before it is through with the last one.
//
// Reset: registers return to 2800 / 300 / 400, the held rate is zero, the
// beat latch is clear, the last beat time is zero. If the receiver stalls,
// the result stays in the output register and one more sample is processed
// before the input side waits.
module pulse_beat_rate_detector_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pbrd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pbrd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pbrd_pkg::InDataW-1:0]  s_axis_tdata,  // sample [11:0], time_ms [43:12], zero
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pbrd_pkg::RateW-1:0]    m_axis_tdata,  // beats_per_minute [15:0]
  output logic                          m_axis_tuser   // new_beat [0]
);
  import pbrd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pbrd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  pbrd_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .sample_i           (s_axis_tdata[SampleW-1:0]),
    .time_ms_i          (s_axis_tdata[SampleW+TimeW-1:SampleW]),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .beats_per_minute_o (m_axis_tdata),
    .new_beat_o         (m_axis_tuser)
  );

`ifndef ASSERT_OFF
  // one sample in flight: input closes after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a sample is in flight");

  // result load never overlaps with a new capture
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.capture && cmd.load_out))
    else $error("capture and output load in the same cycle");

  // divider starts after an evaluation that fired
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.eval && sts.fire) |=> cmd.div_step)
    else $error("divider not started after a beat");
`endif

endmodule

// ===== verif/tb.sv =====
// testbench for the pulse beat rate detector: directed, random and backpressure tests
`timescale 1ns / 100ps

module tb;
  import pbrd_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;  // index past the register list

  typedef struct packed {
    logic [RateW-1:0] bpm;
    logic             new_beat;
  } beat_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [RateW-1:0]    m_axis_tdata;
  logic                m_axis_tuser;

  pulse_beat_rate_detector_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // own copy of the detector state and registers
  logic [SampleW-1:0] thr_cfg;
  logic [SampleW-1:0] hyst_cfg;
  logic [RefrW-1:0]   refr_cfg;
  logic [TimeW-1:0]   last_beat_ms;
  logic               beat_latched;
  logic [RateW-1:0]   held_bpm;

  beat_result_t rate_expect_q[$];
  int unsigned  mismatch_cnt;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  hold_off_cycles;
  logic [TimeW-1:0] now_ms;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when asked for
  initial begin : receiver
    int unsigned hold_left;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles != 0) begin
        hold_left = hold_off_cycles;
        hold_off_cycles <= 0;
        m_axis_tready <= 1'b0;
        while (hold_left != 0) begin
          @(posedge clk_i);
          hold_left--;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    beat_result_t exp_r;
    beat_result_t got_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_r.bpm      = m_axis_tdata;
      got_r.new_beat = m_axis_tuser;
      if (rate_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected transfer: bpm %0d beat %0b", got_r.bpm, got_r.new_beat);
      end else begin
        exp_r = rate_expect_q.pop_front();
        if (got_r.bpm !== exp_r.bpm || got_r.new_beat !== exp_r.new_beat) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected bpm %0d beat %0b, got bpm %0d beat %0b",
                     exp_r.bpm, exp_r.new_beat, got_r.bpm, got_r.new_beat);
        end
      end
    end
  end

  function automatic void predict_rate(input logic [SampleW-1:0] smp,
                                       input logic [TimeW-1:0] ts);
    logic [SampleW-1:0] rearm;
    logic [TimeW-1:0]   interval;
    beat_result_t       r;
    rearm = (thr_cfg > hyst_cfg) ? thr_cfg - hyst_cfg : '0;
    r.new_beat = 1'b0;
    if (smp > thr_cfg && !beat_latched) begin
      interval = ts - last_beat_ms;
      if (interval > TimeW'(refr_cfg)) begin
        held_bpm     = RateW'(32'd60000 / interval);
        last_beat_ms = ts;
        beat_latched = 1'b1;
        r.new_beat   = 1'b1;
      end
    end else if (smp < rearm) begin
      beat_latched = 1'b0;
    end
    r.bpm = held_bpm;
    rate_expect_q.push_back(r);
  endfunction

  task automatic send_sample(input logic [SampleW-1:0] smp, input logic [TimeW-1:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, ts, smp};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_rate(smp, ts);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_THRESHOLD:  thr_cfg  = value[SampleW-1:0];
      CFG_HYSTERESIS: hyst_cfg = value[SampleW-1:0];
      CFG_REFRACTORY: refr_cfg = value[RefrW-1:0];
      default: ;
    endcase
  endtask

  // all results in, then an idle margin before any register write
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (rate_expect_q.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_sample(12'd0, 32'd0);
    send_sample(12'd4095, 32'd0);              // interval zero
    send_sample(12'd4095, 32'd400);            // interval equals refractory time
    send_sample(12'd4095, 32'd401);            // first beat
    send_sample(12'd4095, 32'd2000);           // above threshold while latched
    send_sample(12'd2800, 32'd2001);           // equal to threshold
    send_sample(12'd2500, 32'd2002);           // equal to re-arm level, stays latched
    send_sample(12'd4095, 32'd3000);
    send_sample(12'd2499, 32'd3001);           // re-arm
    send_sample(12'd2801, 32'd3100);
    send_sample(12'd0, 32'd3101);
    send_sample(12'd4095, 32'hFFFF_FFFF);      // very long interval, rate truncates to zero
    send_sample(12'd0, 32'hFFFF_FFFF);
    send_sample(12'd4095, 32'h0000_0190);      // interval across the timestamp wrap
    send_sample(12'd0, 32'h0000_0190);         // re-arm before the registers change
    wait_idle();
  endtask

  task automatic test_register_extremes();
    // threshold zero, hysteresis above threshold: re-arm level clamps at zero
    write_reg(CFG_THRESHOLD, 16'hF000);
    write_reg(CFG_HYSTERESIS, 16'h0FFF);
    write_reg(CFG_REFRACTORY, 16'd0);
    write_reg(CfgIdxSpare, 16'hFFFF);
    send_sample(12'd0, 32'h0000_0191);         // not above a zero threshold
    send_sample(12'd1, 32'h0000_0191);         // interval one, rate 60000
    send_sample(12'd0, 32'h0000_0500);         // never below zero, stays latched
    send_sample(12'd4095, 32'h0000_0600);
    wait_idle();
    write_reg(CFG_THRESHOLD, 16'h0FFF);
    write_reg(CFG_HYSTERESIS, 16'h0000);
    send_sample(12'd4095, 32'h0000_0700);      // nothing is above full-scale threshold
    send_sample(12'd4094, 32'h0000_0701);      // re-arm
    wait_idle();
    write_reg(CFG_THRESHOLD, 16'd2000);
    write_reg(CFG_HYSTERESIS, 16'd100);
    write_reg(CFG_REFRACTORY, 16'hFFFF);
    send_sample(12'd3000, 32'h0001_0190);      // interval equals refractory time
    send_sample(12'd3000, 32'h0001_0191);      // interval too short? no, one past it
    send_sample(12'd3000, 32'h0001_0191);      // latched, same timestamp
    send_sample(12'd1899, 32'h0001_0200);
    send_sample(12'd3000, 32'h0001_0300);      // too short, latch stays clear
    send_sample(12'd1900, 32'h0001_0301);
    send_sample(12'd3000, 32'h0002_0191);
    wait_idle();
    write_reg(CFG_REFRACTORY, 16'd0);
    send_sample(12'd0, 32'h0002_0192);
    send_sample(12'd3000, 32'h0002_0191);      // interval zero with no refractory time
    wait_idle();
  endtask

  task automatic run_pulse_train(input int unsigned n_items);
    int unsigned        period_ms;
    int unsigned        phase_ms;
    logic [SampleW-1:0] smp;
    logic [SampleW-1:0] rearm;
    rearm     = (thr_cfg > hyst_cfg) ? thr_cfg - hyst_cfg : '0;
    period_ms = $urandom_range(1500, 250);
    phase_ms  = 0;
    repeat (n_items) begin
      phase_ms += $urandom_range(25, 1);
      now_ms   += TimeW'(phase_ms) - TimeW'(phase_ms - 0) + TimeW'($urandom_range(0, 0));
      if (phase_ms >= period_ms) begin
        now_ms   += TimeW'(period_ms - (phase_ms - period_ms));
        phase_ms -= period_ms;
        period_ms = $urandom_range(1500, 250);
      end
      now_ms += TimeW'($urandom_range(25, 1));
      if ($urandom_range(99) < 12) begin
        // noise: any level, now and then a jump in time
        smp = SampleW'($urandom);
        if ($urandom_range(9) == 0) now_ms = $urandom;
      end else if (phase_ms < 90) begin
        smp = (thr_cfg == '1) ? '1 : SampleW'($urandom_range(4095, int'(thr_cfg) + 1));
      end else if (phase_ms < 130) begin
        smp = SampleW'($urandom_range(int'(thr_cfg), int'(rearm)));
      end else begin
        smp = (rearm == '0) ? '0 : SampleW'($urandom_range(int'(rearm) - 1, 0));
      end
      send_sample(smp, now_ms);
    end
  endtask

  task automatic test_random_trains();
    for (int p = 0; p < 5; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      if (p == 0) begin
        write_reg(CFG_THRESHOLD, 16'(ThresholdReset));
        write_reg(CFG_HYSTERESIS, 16'(HysteresisReset));
        write_reg(CFG_REFRACTORY, RefractoryReset);
      end else if (p == 3) begin
        write_reg(CFG_THRESHOLD, {4'($urandom), 12'($urandom)});
        write_reg(CFG_HYSTERESIS, {4'($urandom), 12'($urandom)});
        write_reg(CFG_REFRACTORY, 16'($urandom_range(3, 0)));
      end else begin
        write_reg(CFG_THRESHOLD, {4'($urandom), 12'($urandom_range(3500, 1500))});
        write_reg(CFG_HYSTERESIS, {4'($urandom), 12'($urandom_range(1200, 0))});
        write_reg(CFG_REFRACTORY, 16'($urandom_range(700, 150)));
      end
      if (p == 2) now_ms = 32'hFFFF_E000;      // run across the timestamp wrap
      run_pulse_train(360);
      wait_idle();
    end
  endtask

  // receiver holds off for a long stretch while samples keep coming
  task automatic test_output_hold_off();
    send_idle_pct   = 0;
    recv_stall_pct  = 10;
    hold_off_cycles <= 400;
    run_pulse_train(120);
    wait_idle();
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 0;
    mismatch_cnt    = 0;
    now_ms          = 32'd5000;
    thr_cfg         = ThresholdReset;
    hyst_cfg        = HysteresisReset;
    refr_cfg        = RefractoryReset;
    last_beat_ms    = '0;
    beat_latched    = 1'b0;
    held_bpm        = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_random_trains();
    test_output_hold_off();

    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
